>>> design/target_point_penalty_force_top_defines.svh
// Assertion macros shared by the target point penalty force design.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef TARGET_POINT_PENALTY_FORCE_TOP_DEFINES_SVH
`define TARGET_POINT_PENALTY_FORCE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPPF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tppf assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TPPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tppf assertion failed");

`endif

>>> design/tppf_pkg.sv
// Package for the target point penalty force block: payload structs, register
// indexes, the controller state type and the saturation helper. No dependencies.
package tppf_pkg;

  localparam int NUM_AXES   = 3;
  localparam int DIMENSIONS = 3;
  localparam int DATA_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int FRAC_W     = 16;

  localparam logic signed [DATA_W-1:0] BOX_LOW_RESET  = 32'sd0;
  localparam logic signed [DATA_W-1:0] BOX_HIGH_RESET = 32'sd65536;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_LOW_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HIGH_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LOW_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HIGH_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LOW_Z  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HIGH_Z = 3'd5;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [31:0] goal_z;
    logic signed [31:0] stiffness;
    logic signed [31:0] force_in_x;
    logic signed [31:0] force_in_y;
    logic signed [31:0] force_in_z;
    logic               pass_start;
  } in_t;

  typedef struct packed {
    logic signed [31:0] force_out_x;
    logic signed [31:0] force_out_y;
    logic signed [31:0] force_out_z;
    logic        [31:0] node_distance;
    logic        [31:0] pass_peak;
    logic        [31:0] overall_peak;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_DIFF,
    S_MUL,
    S_SUM,
    S_START,
    S_ROOT,
    S_HOLD
  } state_t;

  function automatic logic signed [DATA_W-1:0] sat_s32(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] max_v;
    logic signed [PROD_W-1:0] min_v;
    max_v = {{(PROD_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    min_v = {{(PROD_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    if (v > max_v) begin
      return max_v[DATA_W-1:0];
    end else if (v < min_v) begin
      return min_v[DATA_W-1:0];
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

>>> design/tppf_lane.sv
// One coordinate lane: periodic shift, saturated difference, force update and
// squared difference over four register stages. Depends on tppf_pkg.
module tppf_lane (
  input  logic                                clk,
  input  logic                                active,
  input  logic signed [tppf_pkg::DATA_W-1:0]  pos,
  input  logic signed [tppf_pkg::DATA_W-1:0]  goal,
  input  logic signed [tppf_pkg::DATA_W-1:0]  box_lo,
  input  logic signed [tppf_pkg::DATA_W-1:0]  box_hi,
  input  logic signed [tppf_pkg::DATA_W-1:0]  stiff,
  input  logic signed [tppf_pkg::DATA_W-1:0]  force_in,
  output logic signed [tppf_pkg::DATA_W-1:0]  force_out,
  output logic        [tppf_pkg::PROD_W-1:0]  sq_out
);

  localparam int SH_W = tppf_pkg::DATA_W + 3;
  localparam int DF_W = tppf_pkg::DATA_W + 4;
  localparam int TM_W = tppf_pkg::PROD_W - tppf_pkg::FRAC_W;

  logic signed [SH_W-1:0]              span;
  logic signed [SH_W-1:0]              a_pos_nxt, a_pos_r;
  logic signed [DF_W-1:0]              diff_wide;
  logic signed [tppf_pkg::DATA_W-1:0]  b_diff_r;
  logic signed [tppf_pkg::PROD_W-1:0]  c_prod_r, c_sq_r;
  logic signed [TM_W-1:0]              term;
  logic signed [TM_W:0]                sum_wide;
  logic signed [tppf_pkg::DATA_W-1:0]  d_force_nxt, d_force_r;
  logic        [tppf_pkg::PROD_W-1:0]  d_sq_nxt, d_sq_r;

  always_comb begin
    span = SH_W'(box_hi) - SH_W'(box_lo);
    if (pos < box_lo) begin
      a_pos_nxt = SH_W'(pos) + span;
    end else if (pos > box_hi) begin
      a_pos_nxt = SH_W'(pos) - span;
    end else begin
      a_pos_nxt = SH_W'(pos);
    end
    diff_wide = DF_W'(goal) - DF_W'(a_pos_r);
    term      = TM_W'(c_prod_r >>> tppf_pkg::FRAC_W);
    sum_wide  = (TM_W+1)'(force_in) + (TM_W+1)'(term);
    if (active) begin
      d_force_nxt = tppf_pkg::sat_s32(tppf_pkg::PROD_W'(sum_wide));
      d_sq_nxt    = c_sq_r;
    end else begin
      d_force_nxt = force_in;
      d_sq_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    a_pos_r   <= a_pos_nxt;
    b_diff_r  <= tppf_pkg::sat_s32(tppf_pkg::PROD_W'(diff_wide));
    c_prod_r  <= stiff * b_diff_r;
    c_sq_r    <= b_diff_r * b_diff_r;
    d_force_r <= d_force_nxt;
    d_sq_r    <= d_sq_nxt;
  end

  assign force_out = d_force_r;
  assign sq_out    = d_sq_r;

endmodule

>>> design/tppf_isqrt.sv
// Floor square root of a 64-bit radicand, one root bit per cycle.
// Depends on tppf_pkg.
module tppf_isqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [tppf_pkg::PROD_W-1:0]    radicand,
  output logic                           busy,
  output logic                           done,
  output logic [tppf_pkg::DATA_W-1:0]    root
);

  localparam int RT_W  = tppf_pkg::DATA_W;
  localparam int RM_W  = RT_W + 2;
  localparam int TR_W  = RM_W + 2;
  localparam int CNT_W = $clog2(RT_W);

  logic [tppf_pkg::PROD_W-1:0] rad_r, rad_nxt;
  logic [RM_W-1:0]             rem_r, rem_nxt;
  logic [RT_W-1:0]             root_r, root_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [TR_W-1:0]             trial;

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, rad_r[tppf_pkg::PROD_W-1 -: 2]} - {2'b00, root_r, 2'b01};
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[tppf_pkg::PROD_W-3:0], 2'b00};
      if (!trial[TR_W-1]) begin
        rem_nxt  = trial[RM_W-1:0];
        root_nxt = {root_r[RT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = {rem_r[RM_W-3:0], rad_r[tppf_pkg::PROD_W-1 -: 2]};
        root_nxt = {root_r[RT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(RT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = root_r;

endmodule

>>> design/target_point_penalty_force_top.sv
// Top level of the target point penalty force block: configuration registers,
// coordinate lanes, square-root unit, peak tracking and output register.
// Depends on tppf_pkg, tppf_lane, tppf_isqrt and the defines header.
//
//  channel  ports                            transfer when
//  -------  -------------------------------  ----------------------------
//  input    in_valid, in_ready, in_data      in_valid && in_ready
//  result   out_valid, out_ready, out_data   out_valid && out_ready
//  config   cfg_we, cfg_index, cfg_wdata     cfg_we
//
// One node is in work at a time; after its transfer it passes the 4 lane stages,
// a state that sums the squares and starts the root, the one-bit-per-cycle
// square-root unit, a state that sees it finish and the merge into the output
// register. The next transfer is taken in idle after the merge; a result still
// waiting on out_ready holds the merge. Reset is synchronous, clears control
// state and peaks and loads the box registers with their reset values.
`include "target_point_penalty_force_top_defines.svh"

module target_point_penalty_force_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  tppf_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output tppf_pkg::out_t                     out_data,
  input  logic                               cfg_we,
  input  logic [tppf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tppf_pkg::DATA_W-1:0]        cfg_wdata
);

  localparam int NA = tppf_pkg::NUM_AXES;

  tppf_pkg::state_t state_r, state_nxt;

  logic signed [tppf_pkg::DATA_W-1:0] box_lo_r [NA];
  logic signed [tppf_pkg::DATA_W-1:0] box_hi_r [NA];
  logic signed [tppf_pkg::DATA_W-1:0] box_lo_nxt [NA];
  logic signed [tppf_pkg::DATA_W-1:0] box_hi_nxt [NA];

  tppf_pkg::in_t  in_r;
  tppf_pkg::out_t out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [tppf_pkg::DATA_W-1:0] pass_max_r, pass_max_nxt;
  logic [tppf_pkg::DATA_W-1:0] run_max_r, run_max_nxt;
  logic [tppf_pkg::DATA_W-1:0] pass_base;

  logic signed [tppf_pkg::DATA_W-1:0] pos_a   [NA];
  logic signed [tppf_pkg::DATA_W-1:0] goal_a  [NA];
  logic signed [tppf_pkg::DATA_W-1:0] fin_a   [NA];
  logic signed [tppf_pkg::DATA_W-1:0] fout_a  [NA];
  logic        [tppf_pkg::PROD_W-1:0] sq_a    [NA];
  logic                               stiff_on;

  logic                        sqrt_start, sqrt_busy, sqrt_done;
  logic [tppf_pkg::PROD_W-1:0] sum_sq;
  logic [tppf_pkg::DATA_W-1:0] root;
  logic                        in_xfer, out_load;

  assign in_xfer  = in_valid && in_ready;
  assign in_ready = (state_r == tppf_pkg::S_IDLE);
  assign stiff_on = (in_r.stiffness != '0);

  assign pos_a[0]  = in_r.pos_x;
  assign pos_a[1]  = in_r.pos_y;
  assign pos_a[2]  = in_r.pos_z;
  assign goal_a[0] = in_r.goal_x;
  assign goal_a[1] = in_r.goal_y;
  assign goal_a[2] = in_r.goal_z;
  assign fin_a[0]  = in_r.force_in_x;
  assign fin_a[1]  = in_r.force_in_y;
  assign fin_a[2]  = in_r.force_in_z;

  for (genvar i = 0; i < NA; i++) begin : g_lane
    localparam logic AXIS_ON = (i < tppf_pkg::DIMENSIONS);
    tppf_lane u_lane (
      .clk       (clk),
      .active    (stiff_on && AXIS_ON),
      .pos       (pos_a[i]),
      .goal      (goal_a[i]),
      .box_lo    (box_lo_r[i]),
      .box_hi    (box_hi_r[i]),
      .stiff     (in_r.stiffness),
      .force_in  (fin_a[i]),
      .force_out (fout_a[i]),
      .sq_out    (sq_a[i])
    );
  end

  assign sum_sq = sq_a[0] + sq_a[1] + sq_a[2];

  tppf_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sum_sq),
    .busy     (sqrt_busy),
    .done     (sqrt_done),
    .root     (root)
  );

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      box_lo_nxt[i] = box_lo_r[i];
      box_hi_nxt[i] = box_hi_r[i];
    end
    if (cfg_we) begin
      case (cfg_index)
        tppf_pkg::REG_BOX_LOW_X:  box_lo_nxt[0] = cfg_wdata;
        tppf_pkg::REG_BOX_HIGH_X: box_hi_nxt[0] = cfg_wdata;
        tppf_pkg::REG_BOX_LOW_Y:  box_lo_nxt[1] = cfg_wdata;
        tppf_pkg::REG_BOX_HIGH_Y: box_hi_nxt[1] = cfg_wdata;
        tppf_pkg::REG_BOX_LOW_Z:  box_lo_nxt[2] = cfg_wdata;
        tppf_pkg::REG_BOX_HIGH_Z: box_hi_nxt[2] = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    sqrt_start    = 1'b0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    pass_max_nxt  = pass_max_r;
    run_max_nxt   = run_max_r;
    pass_base     = in_r.pass_start ? '0 : pass_max_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      tppf_pkg::S_IDLE:  if (in_xfer) state_nxt = tppf_pkg::S_SHIFT;
      tppf_pkg::S_SHIFT: state_nxt = tppf_pkg::S_DIFF;
      tppf_pkg::S_DIFF:  state_nxt = tppf_pkg::S_MUL;
      tppf_pkg::S_MUL:   state_nxt = tppf_pkg::S_SUM;
      tppf_pkg::S_SUM:   state_nxt = tppf_pkg::S_START;
      tppf_pkg::S_START: begin
        sqrt_start = 1'b1;
        state_nxt  = tppf_pkg::S_ROOT;
      end
      tppf_pkg::S_ROOT:  if (sqrt_done) state_nxt = tppf_pkg::S_HOLD;
      tppf_pkg::S_HOLD: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          pass_max_nxt  = (root > pass_base) ? root : pass_base;
          run_max_nxt   = (root > run_max_r) ? root : run_max_r;
          out_nxt.force_out_x   = fout_a[0];
          out_nxt.force_out_y   = fout_a[1];
          out_nxt.force_out_z   = fout_a[2];
          out_nxt.node_distance = root;
          out_nxt.pass_peak     = pass_max_nxt;
          out_nxt.overall_peak  = run_max_nxt;
          state_nxt     = tppf_pkg::S_IDLE;
        end
      end
      default: state_nxt = tppf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tppf_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      pass_max_r  <= '0;
      run_max_r   <= '0;
      for (int i = 0; i < NA; i++) begin
        box_lo_r[i] <= tppf_pkg::BOX_LOW_RESET;
        box_hi_r[i] <= tppf_pkg::BOX_HIGH_RESET;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pass_max_r  <= pass_max_nxt;
      run_max_r   <= run_max_nxt;
      for (int i = 0; i < NA; i++) begin
        box_lo_r[i] <= box_lo_nxt[i];
        box_hi_r[i] <= box_hi_nxt[i];
      end
    end
    if (in_xfer) begin
      in_r <= in_data;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `TPPF_ASSERT_SAME(a_idle_sqrt, in_ready, !sqrt_busy)
  `TPPF_ASSERT_SAME(a_done_root, sqrt_done, state_r == tppf_pkg::S_ROOT)
  `TPPF_ASSERT_NEXT(a_load_valid, out_load, out_valid && in_ready)
  `TPPF_ASSERT_SAME(a_peak_order, out_valid, out_data.overall_peak >= out_data.pass_peak)
  `TPPF_ASSERT_SAME(a_dist_peak, out_valid, out_data.pass_peak >= out_data.node_distance)

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench for target_point_penalty_force_top: directed and random nodes checked
// against an in-bench predictor of the penalty force, distance and peaks.
// Depends on tppf_pkg and the RTL only.

module tb_top;

  localparam logic [tppf_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [tppf_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam logic signed [31:0] Q_ONE   = 32'sd65536;
  localparam logic signed [31:0] Q_HALF  = 32'sd32768;
  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 45;

  typedef enum int {BOX_TIGHT, BOX_WILD, BOX_INVERTED} box_shape_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  tppf_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  tppf_pkg::out_t out_data;
  logic           cfg_we = 1'b0;
  logic [tppf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tppf_pkg::DATA_W-1:0]    cfg_wdata = '0;

  logic signed [31:0] box_lo [3];
  logic signed [31:0] box_hi [3];
  logic [31:0] pass_peak_now;
  logic [31:0] overall_peak_now;
  tppf_pkg::out_t force_updates [$];
  tppf_pkg::out_t oldest_update;
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  target_point_penalty_force_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [31:0] floor_root(input logic [63:0] v);
    logic [31:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = {32'b0, r | (32'd1 << b)};
      if (t * t <= v) r = r | (32'd1 << b);
    end
    return r;
  endfunction

  function automatic tppf_pkg::out_t apply_penalty_force(input tppf_pkg::in_t n);
    tppf_pkg::out_t r;
    longint k, p, lo, hi, dlt;
    longint pos_v [3];
    longint goal_v [3];
    longint frc_v [3];
    logic [63:0] sq_sum;
    logic [31:0] reach;
    k = $signed(n.stiffness);
    pos_v[0] = $signed(n.pos_x);
    pos_v[1] = $signed(n.pos_y);
    pos_v[2] = $signed(n.pos_z);
    goal_v[0] = $signed(n.goal_x);
    goal_v[1] = $signed(n.goal_y);
    goal_v[2] = $signed(n.goal_z);
    frc_v[0] = $signed(n.force_in_x);
    frc_v[1] = $signed(n.force_in_y);
    frc_v[2] = $signed(n.force_in_z);
    sq_sum = '0;
    reach = '0;
    if (n.pass_start) pass_peak_now = '0;
    for (int a = 0; a < tppf_pkg::NUM_AXES; a++) begin
      if (k != 0 && a < tppf_pkg::DIMENSIONS) begin
        p = pos_v[a];
        lo = box_lo[a];
        hi = box_hi[a];
        if (p < lo) p = p + (hi - lo);
        else if (p > hi) p = p + (lo - hi);
        dlt = clamp32(goal_v[a] - p);
        frc_v[a] = clamp32(frc_v[a] + ((k * dlt) >>> tppf_pkg::FRAC_W));
        sq_sum = sq_sum + 64'(dlt * dlt);
      end
    end
    if (k != 0) begin
      reach = floor_root(sq_sum);
      if (reach > pass_peak_now) pass_peak_now = reach;
      if (reach > overall_peak_now) overall_peak_now = reach;
    end
    r.force_out_x = frc_v[0][31:0];
    r.force_out_y = frc_v[1][31:0];
    r.force_out_z = frc_v[2][31:0];
    r.node_distance = reach;
    r.pass_peak = pass_peak_now;
    r.overall_peak = overall_peak_now;
    return r;
  endfunction

  function automatic tppf_pkg::in_t make_node(input logic signed [31:0] px, py, pz, gx, gy,
                                              gz, k, fx, fy, fz, input logic ps);
    tppf_pkg::in_t n;
    n.pos_x = px;
    n.pos_y = py;
    n.pos_z = pz;
    n.goal_x = gx;
    n.goal_y = gy;
    n.goal_z = gz;
    n.stiffness = k;
    n.force_in_x = fx;
    n.force_in_y = fy;
    n.force_in_z = fz;
    n.pass_start = ps;
    return n;
  endfunction

  function automatic logic [31:0] pick_q(input logic [31:0] mid);
    case ($urandom_range(9))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(4))
          0: return S32_MIN;
          1: return S32_MAX;
          2: return 32'd0;
          3: return 32'hffff_ffff;
          default: return 32'd1;
        endcase
      end
      default: return mid + ($urandom_range(0, 524288) - 32'd262144);
    endcase
  endfunction

  task automatic compare_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, label, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (force_updates.size() == 0) begin
        $display("%0t: out_data expected none, got %h", $time, out_data);
        mismatches++;
      end else begin
        oldest_update = force_updates.pop_front();
        compare_field("force_out_x", oldest_update.force_out_x, out_data.force_out_x);
        compare_field("force_out_y", oldest_update.force_out_y, out_data.force_out_y);
        compare_field("force_out_z", oldest_update.force_out_z, out_data.force_out_z);
        compare_field("node_distance", oldest_update.node_distance, out_data.node_distance);
        compare_field("pass_peak", oldest_update.pass_peak, out_data.pass_peak);
        compare_field("overall_peak", oldest_update.overall_peak, out_data.overall_peak);
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_node(input tppf_pkg::in_t n);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= n;
    do @(posedge clk); while (!in_ready);
    force_updates = {force_updates, apply_penalty_force(n)};
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (force_updates.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [tppf_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      tppf_pkg::REG_BOX_LOW_X:  box_lo[0] = val;
      tppf_pkg::REG_BOX_HIGH_X: box_hi[0] = val;
      tppf_pkg::REG_BOX_LOW_Y:  box_lo[1] = val;
      tppf_pkg::REG_BOX_HIGH_Y: box_hi[1] = val;
      tppf_pkg::REG_BOX_LOW_Z:  box_lo[2] = val;
      tppf_pkg::REG_BOX_HIGH_Z: box_hi[2] = val;
      default: ;
    endcase
  endtask

  task automatic program_box(input logic [31:0] lx, hx, ly, hy, lz, hz);
    cfg_put(tppf_pkg::REG_BOX_LOW_X, lx);
    cfg_put(tppf_pkg::REG_BOX_HIGH_X, hx);
    cfg_put(tppf_pkg::REG_BOX_LOW_Y, ly);
    cfg_put(tppf_pkg::REG_BOX_HIGH_Y, hy);
    cfg_put(tppf_pkg::REG_BOX_LOW_Z, lz);
    cfg_put(tppf_pkg::REG_BOX_HIGH_Z, hz);
    cfg_put($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7, $urandom);
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_node(make_node(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    send_node(make_node(S32_MAX, S32_MIN, 0, S32_MIN, S32_MAX, 0, 0,
                        S32_MAX, S32_MIN, 32'sd1, 1'b0));
    send_node(make_node(Q_HALF, Q_HALF, Q_HALF, 32'sd16384, 32'sd49152, Q_HALF, Q_ONE,
                        0, 0, 0, 1'b0));
    send_node(make_node(S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX, S32_MAX,
                        S32_MAX, S32_MAX, S32_MAX, 1'b0));
    send_node(make_node(S32_MAX, S32_MAX, S32_MAX, S32_MIN, S32_MIN, S32_MIN, S32_MIN,
                        S32_MIN, S32_MIN, S32_MIN, 1'b0));
    send_node(make_node(Q_HALF, Q_HALF, Q_HALF, Q_ONE, 0, Q_HALF, -32'sd131072,
                        32'sd1000, -32'sd1000, 0, 1'b1));
    send_node(make_node(-Q_HALF, 32'sd98304, 0, 0, 0, Q_ONE, Q_ONE, 0, 0, 0, 1'b0));
    send_node(make_node(0, Q_ONE, -32'sd1, Q_HALF, Q_HALF, Q_HALF, Q_ONE, 0, 0, 0, 1'b0));
    send_node(make_node(Q_HALF, Q_HALF, Q_HALF, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0, 0, 0, 1'b1));
    send_node(make_node(Q_HALF, Q_HALF, Q_HALF, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0, 0, 0, 1'b0));
    send_node(make_node(Q_HALF, Q_HALF, Q_HALF, 0, 0, 0, Q_HALF, 0, 0, 0, 1'b0));
    send_node(make_node(Q_HALF, 0, 0, Q_HALF - 32'sd1, 0, 0, 32'sd1, 0, 0, 0, 1'b1));
    send_node(make_node(Q_HALF, 0, 0, Q_HALF + 32'sd1, 0, 0, -32'sd1, 5, 5, 5, 1'b0));
    send_node(make_node(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 7, 8, 9, 1'b0));
    send_node(make_node(Q_HALF, Q_HALF, Q_HALF, 0, 0, 0, 0, 1, 2, 3, 1'b1));
    send_node(make_node(Q_HALF, 0, 0, 0, 0, 0, Q_ONE, S32_MIN, 0, S32_MAX, 1'b0));
    drain_results();
  endtask

  task automatic test_box_extremes();
    program_box(S32_MIN, S32_MAX, S32_MIN, S32_MAX, S32_MIN, S32_MAX);
    send_node(make_node(S32_MIN, S32_MAX, 0, S32_MAX, S32_MIN, Q_ONE, Q_ONE, 0, 0, 0, 1'b1));
    send_node(make_node(S32_MAX, S32_MIN, -32'sd1, 0, 0, 0, -Q_ONE, 0, 0, 0, 1'b0));
    drain_results();
    cfg_put(REG_SPARE_6, 32'hffff_ffff);
    cfg_put(REG_SPARE_7, 32'h0000_0000);
    program_box(S32_MAX, S32_MIN, S32_MAX, S32_MIN, S32_MAX, S32_MIN);
    send_node(make_node(S32_MIN, 0, S32_MAX, 0, 0, 0, Q_ONE, 0, 0, 0, 1'b1));
    send_node(make_node(S32_MAX, S32_MIN, 0, S32_MAX, S32_MIN, 0, S32_MAX,
                        S32_MIN, S32_MAX, 0, 1'b0));
    drain_results();
    program_box(0, 0, Q_ONE, Q_ONE, -Q_ONE, -Q_ONE);
    send_node(make_node(-32'sd1, Q_ONE + 32'sd1, -Q_ONE, Q_HALF, Q_HALF, Q_HALF, Q_ONE,
                        0, 0, 0, 1'b1));
    send_node(make_node(32'sd1, Q_ONE - 32'sd1, 0, 0, 0, 0, -Q_HALF, 0, 0, 0, 1'b0));
    drain_results();
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct,
                                     input int stall_pct, input box_shape_t shape);
    tppf_pkg::in_t n;
    int left_in_pass;
    logic signed [31:0] lo [3];
    logic signed [31:0] hi [3];
    logic signed [31:0] mid;
    left_in_pass = 0;
    for (int a = 0; a < tppf_pkg::NUM_AXES; a++) begin
      lo[a] = $urandom_range(0, 262144) - 32'd131072;
      hi[a] = lo[a] + $urandom_range(16384, 196608);
      if (shape == BOX_WILD) begin
        lo[a] = $urandom;
        hi[a] = $urandom;
      end else if (shape == BOX_INVERTED) begin
        mid = lo[a];
        lo[a] = hi[a];
        hi[a] = mid;
      end
    end
    program_box(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
    mid = lo[0] + ((hi[0] - lo[0]) >>> 1);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      n.pos_x = pick_q(mid);
      n.pos_y = pick_q(mid);
      n.pos_z = pick_q(mid);
      n.goal_x = pick_q(mid);
      n.goal_y = pick_q(mid);
      n.goal_z = pick_q(mid);
      n.stiffness = ($urandom_range(9) == 0) ? 32'sd0 : pick_q(0);
      n.force_in_x = pick_q(0);
      n.force_in_y = pick_q(0);
      n.force_in_z = pick_q(0);
      if (left_in_pass == 0) begin
        n.pass_start = 1'b1;
        left_in_pass = $urandom_range(1, 20);
      end else begin
        n.pass_start = ($urandom_range(31) == 0);
      end
      left_in_pass--;
      send_node(n);
    end
    drain_results();
  endtask

  initial begin
    box_lo[0] = tppf_pkg::BOX_LOW_RESET;
    box_lo[1] = tppf_pkg::BOX_LOW_RESET;
    box_lo[2] = tppf_pkg::BOX_LOW_RESET;
    box_hi[0] = tppf_pkg::BOX_HIGH_RESET;
    box_hi[1] = tppf_pkg::BOX_HIGH_RESET;
    box_hi[2] = tppf_pkg::BOX_HIGH_RESET;
    pass_peak_now = '0;
    overall_peak_now = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_box_extremes();
    test_random_traffic(250, 0, 0, BOX_TIGHT);
    test_random_traffic(230, 49, 0, BOX_WILD);
    test_random_traffic(230, 0, 49, BOX_TIGHT);
    test_random_traffic(240, 31, 31, BOX_INVERTED);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && force_updates.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/tppf_pkg.sv
design/tppf_lane.sv
design/tppf_isqrt.sv
design/target_point_penalty_force_top.sv
sim/tb_top.sv
